// ===== design/bfti_pkg.sv =====
// ----------------------------------------------------------------------------
// bfti_pkg
// Shared types and constants of the bloom filter test-and-insert block.
// ----------------------------------------------------------------------------
package bfti_pkg;

  localparam int INDEX_BITS_DEF = 20;
  localparam int ROW_SEL_W      = 6;
  localparam int ROW_W          = 1 << ROW_SEL_W;

  localparam logic [31:0] RS_MULT_STEP = 32'd378551;
  localparam logic [31:0] RS_MULT_INIT = 32'd63689;
  localparam logic [31:0] JS_INIT      = 32'd1315423911;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_of_line;
  } in_req_t;

  typedef struct packed {
    logic        already_present;
    logic [31:0] rs_hash_value;
    logic [31:0] js_hash_value;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] rs;
    logic [31:0] js;
  } hashes_t;

  typedef enum logic [1:0] {
    LU_IDLE,
    LU_LOOKUP,
    LU_WR_A,
    LU_WR_B
  } lu_state_t;

endpackage

// ===== design/bfti_hash.sv =====
// ----------------------------------------------------------------------------
// bfti_hash
// RS and JS hash accumulators, one byte per request, restarted after a line.
// ----------------------------------------------------------------------------
module bfti_hash
  import bfti_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  in_req_t req,
  output hashes_t hash_nxt
);

  logic [31:0] rs_acc_r;
  logic [31:0] rs_mult_r;
  logic [31:0] js_acc_r;
  logic [31:0] sbyte;
  logic [31:0] rs_prod;
  logic [31:0] rs_mult_nxt;

  assign sbyte       = {{24{req.char_byte[7]}}, req.char_byte};
  assign rs_prod     = rs_acc_r * rs_mult_r;
  assign rs_mult_nxt = rs_mult_r * RS_MULT_STEP;
  assign hash_nxt.rs = rs_prod + sbyte;
  assign hash_nxt.js = js_acc_r ^ ((js_acc_r << 5) + sbyte + (js_acc_r >> 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_acc_r  <= '0;
      rs_mult_r <= RS_MULT_INIT;
      js_acc_r  <= JS_INIT;
    end else if (step) begin
      if (req.last_of_line) begin
        rs_acc_r  <= '0;
        rs_mult_r <= RS_MULT_INIT;
        js_acc_r  <= JS_INIT;
      end else begin
        rs_acc_r  <= hash_nxt.rs;
        rs_mult_r <= rs_mult_nxt;
        js_acc_r  <= hash_nxt.js;
      end
    end
  end

endmodule

// ===== design/bloom_filter_test_and_insert.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_test_and_insert
// Hashes streamed line bytes and tests/sets two bits of a bloom filter array.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle unless in_ready holds them back. The byte
// marked last starts a lookup in the membership memory (rows of 64 bits, two
// read ports, one write port): LU_LOOKUP reads both rows, LU_WR_A writes the
// first row and hands over the result once the output register is free, and
// LU_WR_B writes the second row when the two bits lie in different rows.
// Hashing of the next line goes on meanwhile; its last byte waits until the
// previous lookup issues its final write. After reset a clearing pass zeroes
// the memory row by row, during which no byte is taken.
module bloom_filter_test_and_insert
  import bfti_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  localparam int ROW_AW = INDEX_BITS - ROW_SEL_W;
  localparam int ROWS   = 2 ** ROW_AW;

  logic [ROW_W-1:0]  bits_mem_r [ROWS];
  logic [ROW_W-1:0]  rd_a_r;
  logic [ROW_W-1:0]  rd_b_r;
  logic [ROW_AW-1:0] clr_cnt_r;
  logic              clearing_r;
  lu_state_t         state_r;
  lu_state_t         state_nxt;
  hashes_t           fin_r;
  hashes_t           hash_nxt;
  logic              out_valid_r;
  out_rsp_t          out_data_r;

  logic              in_acc;
  logic              last_acc;
  logic              lu_free;
  logic              out_load;
  logic              same_row;
  logic [ROW_AW-1:0] row_a;
  logic [ROW_AW-1:0] row_b;
  logic [ROW_W-1:0]  mask_a;
  logic [ROW_W-1:0]  mask_b;
  logic              present;
  logic              mem_re;
  logic              mem_we;
  logic [ROW_AW-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;

  bfti_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_acc),
    .req      (in_data),
    .hash_nxt (hash_nxt)
  );

  assign row_a    = fin_r.rs[INDEX_BITS-1:ROW_SEL_W];
  assign row_b    = fin_r.js[INDEX_BITS-1:ROW_SEL_W];
  assign mask_a   = ROW_W'(1) << fin_r.rs[ROW_SEL_W-1:0];
  assign mask_b   = ROW_W'(1) << fin_r.js[ROW_SEL_W-1:0];
  assign same_row = (row_a == row_b);
  assign present  = ((rd_a_r & mask_a) != '0) && ((rd_b_r & mask_b) != '0);

  assign out_load = (state_r == LU_WR_A) && (!out_valid_r || out_ready);
  assign lu_free  = (state_r == LU_IDLE) || (state_r == LU_WR_B) ||
                    (out_load && same_row);
  assign in_ready = !clearing_r && (!in_data.last_of_line || lu_free);
  assign in_acc   = in_valid && in_ready;
  assign last_acc = in_acc && in_data.last_of_line;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LU_IDLE: begin
        if (last_acc) state_nxt = LU_LOOKUP;
      end
      LU_LOOKUP: begin
        state_nxt = LU_WR_A;
      end
      LU_WR_A: begin
        if (out_load) begin
          if (!same_row) state_nxt = LU_WR_B;
          else if (last_acc) state_nxt = LU_LOOKUP;
          else state_nxt = LU_IDLE;
        end
      end
      LU_WR_B: begin
        state_nxt = last_acc ? LU_LOOKUP : LU_IDLE;
      end
      default: state_nxt = LU_IDLE;
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = row_a;
    mem_wdata = rd_a_r | mask_a;
    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      unique case (state_r)
        LU_IDLE: begin
        end
        LU_LOOKUP: begin
          mem_re = 1'b1;
        end
        LU_WR_A: begin
          mem_we    = out_load;
          mem_waddr = row_a;
          mem_wdata = rd_a_r | mask_a | (same_row ? mask_b : '0);
        end
        LU_WR_B: begin
          mem_we    = 1'b1;
          mem_waddr = row_b;
          mem_wdata = rd_b_r | mask_b;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) bits_mem_r[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      rd_a_r <= bits_mem_r[row_a];
      rd_b_r <= bits_mem_r[row_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + ROW_AW'(1);
      if (clr_cnt_r == '1) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LU_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_acc) fin_r <= hash_nxt;
    if (out_load) begin
      out_data_r.already_present <= present;
      out_data_r.rs_hash_value   <= fin_r.rs;
      out_data_r.js_hash_value   <= fin_r.js;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
